// File: design/ssre_pkg.sv
`default_nettype none

package ssre_pkg;

    // longest row that is coded, in pixels
    localparam int MAX_ROW = 256;

    localparam int ROW_W  = $clog2(MAX_ROW + 1);
    localparam int SKIP_W = (ROW_W > 8) ? ROW_W : 8;

    localparam int LIT_W   = 7;
    localparam int LIT_MAX = 127;

    localparam logic [7:0] SKIP_BASE    = 8'h80;
    localparam logic [7:0] SKIP_FULL    = 8'hFF;
    localparam logic [7:0] ROW_END_CODE = 8'h80;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // register index as seen on paddr[2]
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_COLOR  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_LCNT,
        ST_LDATA,
        ST_REND
    } state_t;

    typedef enum logic [1:0] {
        SRC_SKIP,
        SRC_LCNT,
        SRC_LDATA,
        SRC_REND
    } byte_src_t;

    typedef struct packed {
        logic       enable;
        logic [7:0] color;
    } cfg_t;

    typedef struct packed {
        logic      accept;
        logic      push;
        logic      last;
        byte_src_t src;
    } dp_cmd_t;

    typedef struct packed {
        logic nj_skip;
        logic nj_lit;
        logic nj_rend;
        logic job_lit;
        logic job_rend;
        logic skip_last;
        logic lit_last;
        logic pack_full;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: design/ssre_cfg_regs.sv
`default_nettype none

module ssre_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ssre_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ssre_pkg::DATA_W-1:0]   pwdata,
    output logic      [ssre_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output ssre_pkg::cfg_t                     cfg
);

    logic       enable_reg;
    logic       enable_next;
    logic [7:0] color_reg;
    logic [7:0] color_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        enable_next = enable_reg;
        color_next  = color_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                ssre_pkg::REG_ENABLE: enable_next = pwdata[0];
                ssre_pkg::REG_COLOR:  color_next  = pwdata[7:0];
                default:              enable_next = enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            color_reg  <= 8'h00;
        end
        else
        begin
            enable_reg <= enable_next;
            color_reg  <= color_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ssre_pkg::REG_ENABLE: prdata = {{(ssre_pkg::DATA_W-1){1'b0}}, enable_reg};
            ssre_pkg::REG_COLOR:  prdata = {{(ssre_pkg::DATA_W-8){1'b0}}, color_reg};
            default:              prdata = '0;
        endcase
    end

    assign cfg.enable = enable_reg;
    assign cfg.color  = color_reg;

endmodule

`default_nettype wire

// File: design/ssre_ctrl.sv
`default_nettype none

module ssre_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire ssre_pkg::dp_status_t status,
    output ssre_pkg::dp_cmd_t         cmd
);

    ssre_pkg::state_t state_reg;
    ssre_pkg::state_t state_next;

    logic is_last;
    logic phase;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ssre_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        is_last    = 1'b0;
        phase      = 1'b0;
        cmd.src    = ssre_pkg::SRC_REND;
        cmd.accept = 1'b0;

        unique case (state_reg)
            ssre_pkg::ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    priority if (status.nj_skip)
                        state_next = ssre_pkg::ST_SKIP;
                    else if (status.nj_lit)
                        state_next = ssre_pkg::ST_LCNT;
                    else if (status.nj_rend)
                        state_next = ssre_pkg::ST_REND;
                    else
                        state_next = ssre_pkg::ST_IDLE;
                end
            end
            ssre_pkg::ST_SKIP:
            begin
                phase   = 1'b1;
                cmd.src = ssre_pkg::SRC_SKIP;
                is_last = status.skip_last && !status.job_lit && !status.job_rend;
            end
            ssre_pkg::ST_LCNT:
            begin
                phase   = 1'b1;
                cmd.src = ssre_pkg::SRC_LCNT;
            end
            ssre_pkg::ST_LDATA:
            begin
                phase   = 1'b1;
                cmd.src = ssre_pkg::SRC_LDATA;
                is_last = status.lit_last && !status.job_rend;
            end
            ssre_pkg::ST_REND:
            begin
                phase   = 1'b1;
                cmd.src = ssre_pkg::SRC_REND;
                is_last = 1'b1;
            end
            default:
            begin
                state_next = ssre_pkg::ST_IDLE;
            end
        endcase

        // a byte that closes a word needs the output register free
        cmd.push = phase && (!(status.pack_full || is_last) || status.out_free);
        cmd.last = is_last;

        if (cmd.push)
        begin
            unique case (state_reg)
                ssre_pkg::ST_SKIP:
                begin
                    if (status.skip_last)
                    begin
                        priority if (status.job_lit)
                            state_next = ssre_pkg::ST_LCNT;
                        else if (status.job_rend)
                            state_next = ssre_pkg::ST_REND;
                        else
                            state_next = ssre_pkg::ST_IDLE;
                    end
                end
                ssre_pkg::ST_LCNT:  state_next = ssre_pkg::ST_LDATA;
                ssre_pkg::ST_LDATA:
                begin
                    if (status.lit_last)
                        state_next = status.job_rend ? ssre_pkg::ST_REND : ssre_pkg::ST_IDLE;
                end
                ssre_pkg::ST_REND:  state_next = ssre_pkg::ST_IDLE;
                default:            state_next = state_reg;
            endcase
        end
    end

    assign in_stall = (state_reg != ssre_pkg::ST_IDLE);

endmodule

`default_nettype wire

// File: design/ssre_datapath.sv
`default_nettype none

module ssre_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ssre_pkg::cfg_t       cfg,
    input  wire logic [7:0]           pixel,
    input  wire logic                 end_of_row,
    input  wire ssre_pkg::dp_cmd_t    cmd,
    output ssre_pkg::dp_status_t      status,
    output logic [63:0]               code_word,
    output logic [3:0]                byte_count,
    output logic                      last_of_run,
    output logic                      row_overflow,
    output logic                      out_valid,
    input  wire logic                 out_stall
);

    localparam int LW = ssre_pkg::LIT_W;
    localparam int RW = ssre_pkg::ROW_W;
    localparam int SW = ssre_pkg::SKIP_W;

    // coder state
    logic [LW-1:0] lit_count_reg;
    logic [LW-1:0] lit_count_next;
    logic [SW-1:0] skip_count_reg;
    logic [SW-1:0] skip_count_next;
    logic [RW-1:0] row_pos_reg;
    logic [RW-1:0] row_pos_next;
    logic          ovf_seen_reg;
    logic          ovf_seen_next;

    // current job
    logic [SW-1:0] skip_rem_reg;
    logic [SW-1:0] skip_rem_next;
    logic [LW-1:0] lit_len_reg;
    logic [LW-1:0] lit_len_next;
    logic [LW-1:0] lit_idx_reg;
    logic [LW-1:0] lit_idx_next;
    logic          rend_reg;
    logic          rend_next;
    logic          flag_reg;
    logic          flag_next;

    // packer and output word
    logic [63:0]   pack_reg;
    logic [63:0]   pack_next;
    logic [2:0]    pack_cnt_reg;
    logic [2:0]    pack_cnt_next;
    logic [63:0]   word_reg;
    logic [63:0]   word_next;
    logic [3:0]    count_reg;
    logic [3:0]    count_next;
    logic          last_reg;
    logic          last_next;
    logic          oflag_reg;
    logic          oflag_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    // literal buffer
    logic [7:0]    lit_mem [ssre_pkg::LIT_MAX];
    logic [7:0]    rd_data_reg;
    logic [LW-1:0] rd_addr;
    logic          lit_wr;

    // accept-time job decode
    logic          ovf_path;
    logic          transp;
    logic [SW-1:0] j_skip;
    logic [LW-1:0] j_lit;
    logic [LW-1:0] lit_after;
    logic [LW-1:0] lit_plus;

    logic          skip_big;
    logic          skip_last;
    logic          lit_last;
    logic [7:0]    cur_byte;
    logic [63:0]   word_ins;
    logic          complete;
    logic          out_free;

    always_comb
    begin
        ovf_path        = (row_pos_reg >= RW'(ssre_pkg::MAX_ROW));
        transp          = cfg.enable && (pixel == cfg.color);
        lit_plus        = lit_count_reg + LW'(1);
        j_skip          = '0;
        j_lit           = '0;
        lit_after       = lit_count_reg;
        skip_count_next = skip_count_reg;
        row_pos_next    = row_pos_reg;
        ovf_seen_next   = ovf_seen_reg || ovf_path;
        lit_wr          = 1'b0;

        if (!ovf_path)
        begin
            row_pos_next = row_pos_reg + RW'(1);
            if (transp)
            begin
                j_lit           = lit_count_reg;
                lit_after       = '0;
                skip_count_next = skip_count_reg + SW'(1);
            end
            else
            begin
                j_skip          = skip_count_reg;
                skip_count_next = '0;
                lit_wr          = 1'b1;
                // a full chunk goes out at once
                if (lit_plus == LW'(ssre_pkg::LIT_MAX))
                begin
                    j_lit     = lit_plus;
                    lit_after = '0;
                end
                else
                begin
                    lit_after = lit_plus;
                end
            end
        end

        if (end_of_row)
        begin
            if (lit_after != '0)
                j_lit = lit_after;
            lit_after       = '0;
            skip_count_next = '0;
            row_pos_next    = '0;
            ovf_seen_next   = 1'b0;
        end
        lit_count_next = lit_after;
    end

    assign skip_big  = (skip_rem_reg >= SW'(ssre_pkg::LIT_MAX));
    assign skip_last = (skip_rem_reg <= SW'(ssre_pkg::LIT_MAX));
    assign lit_last  = (lit_idx_reg == (lit_len_reg - LW'(1)));

    always_comb
    begin
        unique case (cmd.src)
            ssre_pkg::SRC_SKIP:
                cur_byte = skip_big ? ssre_pkg::SKIP_FULL
                                    : (ssre_pkg::SKIP_BASE | {1'b0, skip_rem_reg[6:0]});
            ssre_pkg::SRC_LCNT:  cur_byte = {{(8-LW){1'b0}}, lit_len_reg};
            ssre_pkg::SRC_LDATA: cur_byte = rd_data_reg;
            ssre_pkg::SRC_REND:  cur_byte = ssre_pkg::ROW_END_CODE;
            default:             cur_byte = ssre_pkg::ROW_END_CODE;
        endcase
    end

    // read one entry ahead so the next literal is ready when this one goes out
    always_comb
    begin
        rd_addr = '0;
        if (cmd.src == ssre_pkg::SRC_LDATA)
        begin
            if (cmd.push && !lit_last)
                rd_addr = lit_idx_reg + LW'(1);
            else
                rd_addr = lit_idx_reg;
        end
    end

    always_comb
    begin
        skip_rem_next = skip_rem_reg;
        lit_len_next  = lit_len_reg;
        lit_idx_next  = lit_idx_reg;
        rend_next     = rend_reg;
        flag_next     = flag_reg;
        if (cmd.accept)
        begin
            skip_rem_next = j_skip;
            lit_len_next  = j_lit;
            lit_idx_next  = '0;
            rend_next     = end_of_row;
            flag_next     = ovf_seen_reg || ovf_path;
        end
        else if (cmd.push)
        begin
            if (cmd.src == ssre_pkg::SRC_SKIP)
                skip_rem_next = skip_last ? '0 : (skip_rem_reg - SW'(ssre_pkg::LIT_MAX));
            if (cmd.src == ssre_pkg::SRC_LDATA)
                lit_idx_next = lit_idx_reg + LW'(1);
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign complete = cmd.push && ((pack_cnt_reg == 3'd7) || cmd.last);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            word_ins[8*i +: 8] = (pack_cnt_reg == 3'(i)) ? cur_byte : pack_reg[8*i +: 8];
        end

        pack_next      = pack_reg;
        pack_cnt_next  = pack_cnt_reg;
        word_next      = word_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        oflag_next     = oflag_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (complete)
        begin
            pack_next      = '0;
            pack_cnt_next  = '0;
            word_next      = word_ins;
            count_next     = {1'b0, pack_cnt_reg} + 4'd1;
            last_next      = cmd.last;
            oflag_next     = flag_reg;
            out_valid_next = 1'b1;
        end
        else if (cmd.push)
        begin
            pack_next     = word_ins;
            pack_cnt_next = pack_cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_count_reg  <= '0;
            skip_count_reg <= '0;
            row_pos_reg    <= '0;
            ovf_seen_reg   <= 1'b0;
            skip_rem_reg   <= '0;
            lit_len_reg    <= '0;
            lit_idx_reg    <= '0;
            rend_reg       <= 1'b0;
            flag_reg       <= 1'b0;
            pack_reg       <= '0;
            pack_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                lit_count_reg  <= lit_count_next;
                skip_count_reg <= skip_count_next;
                row_pos_reg    <= row_pos_next;
                ovf_seen_reg   <= ovf_seen_next;
            end
            skip_rem_reg  <= skip_rem_next;
            lit_len_reg   <= lit_len_next;
            lit_idx_reg   <= lit_idx_next;
            rend_reg      <= rend_next;
            flag_reg      <= flag_next;
            pack_reg      <= pack_next;
            pack_cnt_reg  <= pack_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        count_reg <= count_next;
        last_reg  <= last_next;
        oflag_reg <= oflag_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && lit_wr)
            lit_mem[lit_count_reg] <= pixel;
        rd_data_reg <= lit_mem[rd_addr];
    end

    assign status.nj_skip   = (j_skip != '0);
    assign status.nj_lit    = (j_lit != '0);
    assign status.nj_rend   = end_of_row;
    assign status.job_lit   = (lit_len_reg != '0);
    assign status.job_rend  = rend_reg;
    assign status.skip_last = skip_last;
    assign status.lit_last  = lit_last;
    assign status.pack_full = (pack_cnt_reg == 3'd7);
    assign status.out_free  = out_free;

    assign code_word    = word_reg;
    assign byte_count   = count_reg;
    assign last_of_run  = last_reg;
    assign row_overflow = oflag_reg;
    assign out_valid    = out_valid_reg;

`ifndef ASSERT_OFF
    a_close_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        complete |-> out_free)
        else $error("word closed while output register busy");

    a_inner_word_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (count_reg == 4'd8))
        else $error("word short of eight bytes before the last one");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && (cmd.src == ssre_pkg::SRC_SKIP)) |-> (skip_rem_reg != '0))
        else $error("skip code pushed with nothing left to skip");

    a_lit_below_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (lit_count_reg < LW'(ssre_pkg::LIT_MAX)))
        else $error("literal count reached a full chunk without flushing");
`endif

endmodule

`default_nettype wire

// File: design/sprite_skip_run_encoder_core.sv
// a pixel is taken while idle; one that completes no code leaves the encoder idle, one
// that completes codes holds off the next pixel while its code bytes (1 to 129 bytes)
// go out one per cycle as output stalls allow, via the byte-wide packer and the
// literal buffer read port; a word is output in the cycle after its last byte is packed
// reset clears config, row state, packer and output valid; the literal buffer holds
// no reset, and only entries that were written are used
`default_nettype none

module sprite_skip_run_encoder_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ssre_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ssre_pkg::DATA_W-1:0]  pwdata,
    output logic      [ssre_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [7:0]                   pixel,
    input  wire logic                         end_of_row,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [63:0]                       code_word,
    output logic [3:0]                        byte_count,
    output logic                              last_of_run,
    output logic                              row_overflow
);

    ssre_pkg::cfg_t       cfg;
    ssre_pkg::dp_cmd_t    cmd;
    ssre_pkg::dp_status_t status;

    ssre_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ssre_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pixel        (pixel),
        .end_of_row   (end_of_row),
        .cmd          (cmd),
        .status       (status),
        .code_word    (code_word),
        .byte_count   (byte_count),
        .last_of_run  (last_of_run),
        .row_overflow (row_overflow),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

endmodule

`default_nettype wire

// File: tb/sprite_code_checker.sv
module sprite_code_checker
    import ssre_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    input  wire logic              pready,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic [7:0]        pixel,
    input  wire logic              end_of_row,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic [63:0]       code_word,
    input  wire logic [3:0]        byte_count,
    input  wire logic              last_of_run,
    input  wire logic              row_overflow,
    output int                     errors,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] code;
        logic [3:0]  count;
        logic        last;
        logic        ovf;
    } coded_word_t;

    coded_word_t pending_words[$];
    logic [7:0]  code_bytes[$];

    // encoder state as the block should hold it
    logic [7:0]  lit_mem[0:LIT_MAX-1];
    int unsigned lit_n;
    int unsigned skip_n;
    int unsigned row_pos;
    logic        ovf_seen;
    logic        cfg_enable;
    logic [7:0]  cfg_color;

    initial begin
        errors = 0;
        outstanding = 0;
    end

    function automatic void emit_literals();
        if (lit_n == 0)
            return;
        code_bytes.push_back(8'(lit_n));
        for (int i = 0; i < int'(lit_n); i++)
            code_bytes.push_back(lit_mem[i]);
        lit_n = 0;
    endfunction

    function automatic void emit_skips();
        int unsigned s;
        s = skip_n;
        while (s >= LIT_MAX) begin
            code_bytes.push_back(SKIP_FULL);
            s -= LIT_MAX;
        end
        if (s > 0)
            code_bytes.push_back(8'(SKIP_BASE + s));
        skip_n = 0;
    endfunction

    function automatic void pack_words(logic ovf);
        coded_word_t w;
        int nwords;
        int cnt;
        nwords = (code_bytes.size() + 7) / 8;
        for (int k = 0; k < nwords; k++) begin
            w = '0;
            cnt = code_bytes.size() - k * 8;
            if (cnt > 8)
                cnt = 8;
            for (int j = 0; j < cnt; j++)
                w.code[8*j +: 8] = code_bytes[k*8 + j];
            w.count = 4'(cnt);
            w.last = (k == nwords - 1);
            w.ovf = ovf;
            pending_words.push_back(w);
        end
        code_bytes.delete();
    endfunction

    function automatic void encode_pixel(logic [7:0] px, logic eor);
        logic ovf;
        if (row_pos >= MAX_ROW) begin
            ovf_seen = 1'b1;
        end
        else begin
            row_pos++;
            if (cfg_enable && px == cfg_color) begin
                emit_literals();
                skip_n++;
            end
            else begin
                // a skip run left over from a transparent stretch goes out first
                if (skip_n > 0)
                    emit_skips();
                if (lit_n < LIT_MAX) begin
                    lit_mem[lit_n] = px;
                    lit_n++;
                end
                if (lit_n >= LIT_MAX)
                    emit_literals();
            end
        end
        ovf = ovf_seen;
        if (eor) begin
            emit_literals();
            skip_n = 0;
            code_bytes.push_back(ROW_END_CODE);
            row_pos = 0;
            ovf_seen = 1'b0;
        end
        pack_words(ovf);
    endfunction

    always @(posedge clk) begin : watch
        coded_word_t want;
        if (!rst_n) begin
            lit_n = 0;
            skip_n = 0;
            row_pos = 0;
            ovf_seen = 1'b0;
            cfg_enable = 1'b0;
            cfg_color = 8'h00;
            pending_words.delete();
        end
        else begin
            if (out_valid && !out_stall) begin
                if (pending_words.size() == 0) begin
                    errors++;
                    $display("%0t: code word %h arrived with none expected", $time, code_word);
                end
                else begin
                    want = pending_words.pop_front();
                    if (code_word !== want.code) begin
                        errors++;
                        $display("%0t: code_word expected %h, got %h",
                                 $time, want.code, code_word);
                    end
                    if (byte_count !== want.count) begin
                        errors++;
                        $display("%0t: byte_count expected %0d, got %0d",
                                 $time, want.count, byte_count);
                    end
                    if (last_of_run !== want.last) begin
                        errors++;
                        $display("%0t: last_of_run expected %b, got %b",
                                 $time, want.last, last_of_run);
                    end
                    if (row_overflow !== want.ovf) begin
                        errors++;
                        $display("%0t: row_overflow expected %b, got %b",
                                 $time, want.ovf, row_overflow);
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_COLOR)
                    cfg_color = pwdata[7:0];
                else
                    cfg_enable = pwdata[0];
            end
            if (in_valid && !in_stall)
                encode_pixel(pixel, end_of_row);
        end
        outstanding = pending_words.size();
    end

endmodule

// File: tb/sprite_skip_run_encoder_core_test.sv
module sprite_skip_run_encoder_core_test;
    import ssre_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 16;
    localparam int QUIET_TAIL     = 8;
    localparam int PHASE_ITEMS    = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        pixel;
    logic              end_of_row;
    logic              out_valid;
    logic              out_stall;
    logic [63:0]       code_word;
    logic [3:0]        byte_count;
    logic              last_of_run;
    logic              row_overflow;

    int errors;
    int outstanding;
    int sent_count;
    int stalled_cycles;

    bit quiet;
    bit gappy;
    bit hold_req;
    bit hold_served;

    logic       cur_enable;
    logic [7:0] cur_color;

    sprite_skip_run_encoder_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .end_of_row   (end_of_row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_word    (code_word),
        .byte_count   (byte_count),
        .last_of_run  (last_of_run),
        .row_overflow (row_overflow)
    );

    sprite_code_checker code_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .end_of_row   (end_of_row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_word    (code_word),
        .byte_count   (byte_count),
        .last_of_run  (last_of_run),
        .row_overflow (row_overflow),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // nothing taken on either channel for too long means the block hung
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stalled_cycles <= 0;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver side: random stall bursts, one long hold-off, none at the end
    initial
    begin
        int n;
        forever
        begin
            if (quiet)
            begin
                out_stall <= 1'b0;
                n = 1;
            end
            else if (hold_req && !hold_served)
            begin
                out_stall <= 1'b1;
                n = HOLD_CYCLES;
                hold_served = 1'b1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 8);
            end
            else
            begin
                out_stall <= 1'b0;
                n = $urandom_range(1, 16);
            end
            repeat (n) @(posedge clk);
        end
    end

    task automatic send_pixel(input logic [7:0] px, input logic eor);
        in_valid <= 1'b1;
        pixel <= px;
        end_of_row <= eor;
        do @(posedge clk); while (in_stall);
        sent_count++;
        if (!quiet && gappy && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_row(input int len);
        bit clear_run;
        logic [7:0] px;
        clear_run = $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                clear_run = !clear_run;
            px = clear_run ? cur_color : 8'($urandom);
            send_pixel(px, i == len - 1);
        end
    endtask

    // wait until every expected word is out, then let trailing work settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic en, input logic [7:0] color);
        for (int r = 0; r < 2; r++)
        begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= (r == 0) ? {REG_ENABLE, 2'b00} : {REG_COLOR, 2'b00};
            pwdata <= (r == 0) ? DATA_W'(en) : DATA_W'(color);
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_enable = en;
        cur_color = color;
    endtask

    initial
    begin
        logic [7:0] px;
        int goal;
        int phase_start;
        int phase;
        int len;

        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        pixel <= 8'h00;
        end_of_row <= 1'b0;
        cur_enable = 1'b0;
        cur_color = 8'h00;
        sent_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: everything is literal
        gappy = 1'b1;
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b1);

        // skips between literals, trailing transparent run dropped at row end
        drain();
        write_config(1'b1, 8'h00);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h5A, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hA5, 1'b1);
        send_pixel(8'h7F, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b1);

        // transparent row of one pixel, then transparency switched off mid-run
        drain();
        write_config(1'b1, 8'hFF);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b0);
        drain();
        write_config(1'b0, 8'hFF);
        send_pixel(8'hFF, 1'b1);

        // one over-long row: a skip run past 127, a full literal chunk, overflow;
        // the receiver holds off meanwhile so the input backs up
        drain();
        write_config(1'b1, 8'h3C);
        gappy = 1'b0;
        hold_req <= 1'b1;
        for (int i = 0; i <= MAX_ROW + 1; i++)
        begin
            px = 8'($urandom);
            if (px == cur_color)
                px = px ^ 8'h01;
            send_pixel((i < 128) ? cur_color : px, i == MAX_ROW + 1);
        end

        goal = sent_count + RANDOM_ITEMS;
        phase = 0;
        while (sent_count < goal)
        begin
            drain();
            case (phase % 4)
                0: write_config(1'b1, 8'h00);
                1: write_config(1'b1, 8'hFF);
                2: write_config(1'b0, 8'($urandom));
                default: write_config(1'($urandom_range(0, 1)), 8'($urandom));
            endcase
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_ITEMS && sent_count < goal)
            begin
                gappy = $urandom_range(0, 1);
                if (!quiet && sent_count >= goal - QUIET_TAIL)
                    quiet <= 1'b1;
                if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(120, 200);
                else
                    len = $urandom_range(1, 12);
                if (len > goal - sent_count)
                    len = goal - sent_count;
                send_row(len);
            end
            phase++;
        end

        quiet <= 1'b1;
        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
